// File: hw/rtl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg: shared definitions of the allocation size-class rounder
// Field widths, default configuration constants and the class result type.
// ----------------------------------------------------------------------------
package asc_pkg;

   localparam int SIZE_W  = 32;
   localparam int LOG2_W  = 5;
   localparam int STEP_W  = 3;
   localparam int PAGES_W = 20;

   localparam int QUANTUM_LOG2_DEF  = 4;
   localparam int STEPS_LOG2_DEF    = 2;
   localparam int PAGE_LOG2_DEF     = 13;
   localparam int CHUNK_LOG2_DEF    = 24;
   localparam int SUBPAGE_LIMIT_DEF = 28672;

   typedef struct packed {
      logic [SIZE_W-1:0] rounded_size;
      logic [LOG2_W-1:0] group_log2;
      logic [LOG2_W-1:0] delta_log2;
      logic [STEP_W-1:0] step_count;
      logic              was_exact;
   } class_type;

   typedef struct packed {
      logic [PAGES_W-1:0] page_count;
      logic               multi_page;
      logic               sub_page;
   } page_type;

endpackage

// File: hw/rtl/asc_req_if.sv
// ----------------------------------------------------------------------------
// asc_req_if: request channel of the size-class rounder
// Valid/ready channel that carries one requested allocation size.
// ----------------------------------------------------------------------------
interface asc_req_if;
   logic                      valid;
   logic                      ready;
   logic [asc_pkg::SIZE_W-1:0] request_size;

   modport source(output valid, output request_size, input ready);
   modport sink(input valid, input request_size, output ready);
endinterface

// File: hw/rtl/asc_rsp_if.sv
// ----------------------------------------------------------------------------
// asc_rsp_if: result channel of the size-class rounder
// Valid/ready channel that carries the size class and page information.
// ----------------------------------------------------------------------------
interface asc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [asc_pkg::SIZE_W-1:0]  rounded_size;
   logic [asc_pkg::LOG2_W-1:0]  group_log2;
   logic [asc_pkg::LOG2_W-1:0]  delta_log2;
   logic [asc_pkg::STEP_W-1:0]  step_count;
   logic                        was_exact;
   logic [asc_pkg::PAGES_W-1:0] page_count;
   logic                        multi_page;
   logic                        sub_page;

   modport source(output valid, output rounded_size, output group_log2, output delta_log2,
                  output step_count, output was_exact, output page_count,
                  output multi_page, output sub_page, input ready);
   modport sink(input valid, input rounded_size, input group_log2, input delta_log2,
                input step_count, input was_exact, input page_count,
                input multi_page, input sub_page, output ready);
endinterface

// File: hw/rtl/asc_class_calc.sv
// ----------------------------------------------------------------------------
// asc_class_calc: size-class rounding logic
// Finds the group of a request with a leading-one detector and rounds it up
// to its group's next class in canonical form; sizes above the chunk pass as is.
// ----------------------------------------------------------------------------
module asc_class_calc #(
   parameter int QUANTUM_LOG2 = asc_pkg::QUANTUM_LOG2_DEF,
   parameter int STEPS_LOG2   = asc_pkg::STEPS_LOG2_DEF,
   parameter int CHUNK_LOG2   = asc_pkg::CHUNK_LOG2_DEF
) (
   input  logic [asc_pkg::SIZE_W-1:0] request_size,
   output asc_pkg::class_type         cls
);

   localparam int NW = STEPS_LOG2 + 1;
   localparam logic [asc_pkg::SIZE_W-1:0] QUANTUM   = asc_pkg::SIZE_W'(1) << QUANTUM_LOG2;
   localparam logic [asc_pkg::SIZE_W-1:0] FIRST_TOP =
      asc_pkg::SIZE_W'(1) << (QUANTUM_LOG2 + STEPS_LOG2);
   localparam logic [asc_pkg::SIZE_W-1:0] CHUNK     = asc_pkg::SIZE_W'(1) << CHUNK_LOG2;
   localparam logic [asc_pkg::LOG2_W-1:0] Q_LOG2    = asc_pkg::LOG2_W'(QUANTUM_LOG2);
   localparam logic [asc_pkg::LOG2_W-1:0] S_LOG2    = asc_pkg::LOG2_W'(STEPS_LOG2);
   localparam logic [NW-1:0]              ONE_N     = NW'(1);
   localparam logic [NW-1:0]              FULL_N    = NW'(1) << STEPS_LOG2;

   logic [asc_pkg::SIZE_W-1:0] therm;
   logic [asc_pkg::SIZE_W-1:0] lead;
   logic [asc_pkg::LOG2_W-1:0] top;
   logic                       is_small;
   logic                       is_big;
   logic                       is_first;
   logic [asc_pkg::LOG2_W-1:0] grp;
   logic [asc_pkg::LOG2_W-1:0] dlt;
   logic [asc_pkg::SIZE_W-1:0] low_mask;
   logic [asc_pkg::SIZE_W-1:0] shifted;
   logic                       rem_zero;
   logic [NW-1:0]              n_raw;
   logic [NW-1:0]              n_fin;

   always_comb begin
      therm = request_size;
      therm = therm | (therm >> 1);
      therm = therm | (therm >> 2);
      therm = therm | (therm >> 4);
      therm = therm | (therm >> 8);
      therm = therm | (therm >> 16);
      lead  = therm & ~(therm >> 1);
      top   = '0;
      for (int i = 0; i < asc_pkg::SIZE_W; i++) begin
         top = top | (lead[i] ? asc_pkg::LOG2_W'(i) : '0);
      end
   end

   always_comb begin
      is_small = request_size <= QUANTUM;
      is_big   = request_size > CHUNK;
      is_first = request_size <= FIRST_TOP;
      grp      = is_first ? Q_LOG2 : top;
      dlt      = is_first ? Q_LOG2 : top - S_LOG2;
      low_mask = ~({asc_pkg::SIZE_W{1'b1}} << dlt);
      rem_zero = (request_size & low_mask) == '0;
      shifted  = request_size >> dlt;
      n_raw    = NW'(shifted) - (is_first ? ONE_N : FULL_N);
      n_fin    = n_raw;

      cls = '0;
      if (is_small) begin
         cls.rounded_size = QUANTUM;
         cls.group_log2   = Q_LOG2;
         cls.delta_log2   = Q_LOG2;
         cls.was_exact    = request_size == QUANTUM;
      end else if (is_big) begin
         cls.rounded_size = request_size;
      end else begin
         cls.was_exact  = rem_zero;
         cls.group_log2 = grp;
         cls.delta_log2 = dlt;
         if (rem_zero) begin
            cls.rounded_size = request_size;
            if (n_raw == '0 && !is_first) begin
               // A power of two is reported as the last step of the group below.
               cls.group_log2 = grp - asc_pkg::LOG2_W'(1);
               cls.delta_log2 = dlt - asc_pkg::LOG2_W'(1);
               n_fin          = FULL_N;
            end
         end else begin
            cls.rounded_size = (request_size & ~low_mask) + (asc_pkg::SIZE_W'(1) << dlt);
            n_fin            = n_raw + ONE_N;
         end
         cls.step_count = asc_pkg::STEP_W'(n_fin);
      end
   end

endmodule

// File: hw/rtl/asc_page_calc.sv
// ----------------------------------------------------------------------------
// asc_page_calc: page count and page flags
// Counts the pages that cover the raw request and classifies the rounded size.
// ----------------------------------------------------------------------------
module asc_page_calc #(
   parameter int PAGE_LOG2     = asc_pkg::PAGE_LOG2_DEF,
   parameter int SUBPAGE_LIMIT = asc_pkg::SUBPAGE_LIMIT_DEF
) (
   input  logic [asc_pkg::SIZE_W-1:0] request_size,
   input  logic [asc_pkg::SIZE_W-1:0] rounded_size,
   input  logic [asc_pkg::LOG2_W-1:0] delta_log2,
   output asc_pkg::page_type          pg
);

   localparam int SUM_W = (PAGE_LOG2 + asc_pkg::PAGES_W > asc_pkg::SIZE_W + 1) ?
                          PAGE_LOG2 + asc_pkg::PAGES_W : asc_pkg::SIZE_W + 1;
   localparam logic [asc_pkg::SIZE_W-1:0] PAGE      = asc_pkg::SIZE_W'(1) << PAGE_LOG2;
   localparam logic [asc_pkg::SIZE_W-1:0] PAGE_MASK = PAGE - asc_pkg::SIZE_W'(1);
   localparam logic [asc_pkg::SIZE_W-1:0] SUB_LIMIT = asc_pkg::SIZE_W'(SUBPAGE_LIMIT);
   localparam logic [asc_pkg::LOG2_W-1:0] P_LOG2    = asc_pkg::LOG2_W'(PAGE_LOG2);

   logic [SUM_W-1:0] sum;

   always_comb begin
      sum           = SUM_W'(request_size) + SUM_W'(PAGE_MASK);
      pg.page_count = (request_size <= PAGE) ? asc_pkg::PAGES_W'(1)
                                             : sum[PAGE_LOG2 +: asc_pkg::PAGES_W];
      pg.multi_page = (delta_log2 >= P_LOG2) || ((rounded_size & PAGE_MASK) == '0);
      pg.sub_page   = rounded_size <= SUB_LIMIT;
   end

endmodule

// File: hw/rtl/alloc_size_class_rounder.sv
// ----------------------------------------------------------------------------
// alloc_size_class_rounder: allocation size-class rounder
// Rounds a requested size to its size class and reports page information.
// ----------------------------------------------------------------------------
// The block takes one request in every cycle unless a waiting result stalls
// it: the request is captured in an input register, the class and page
// logic runs in one pass, and the result waits in an output register until
// it is taken. A waiting result does not block the next request while the
// input register is free or moving on.
module alloc_size_class_rounder #(
   parameter int QUANTUM_LOG2  = asc_pkg::QUANTUM_LOG2_DEF,
   parameter int STEPS_LOG2    = asc_pkg::STEPS_LOG2_DEF,
   parameter int PAGE_LOG2     = asc_pkg::PAGE_LOG2_DEF,
   parameter int CHUNK_LOG2    = asc_pkg::CHUNK_LOG2_DEF,
   parameter int SUBPAGE_LIMIT = asc_pkg::SUBPAGE_LIMIT_DEF
) (
   input logic       clock,
   input logic       reset,
   asc_req_if.sink   req_chan,
   asc_rsp_if.source rsp_chan
);

   logic                       req_valid_ff;
   logic [asc_pkg::SIZE_W-1:0] req_size_ff;
   logic                       rsp_valid_ff;
   asc_pkg::class_type         cls_ff;
   asc_pkg::page_type          pg_ff;
   asc_pkg::class_type         cls_in;
   asc_pkg::page_type          pg_in;
   logic                       rsp_free;
   logic                       req_free;

   asc_class_calc #(
      .QUANTUM_LOG2(QUANTUM_LOG2),
      .STEPS_LOG2  (STEPS_LOG2),
      .CHUNK_LOG2  (CHUNK_LOG2)
   ) u_class (
      .request_size(req_size_ff),
      .cls         (cls_in)
   );

   asc_page_calc #(
      .PAGE_LOG2    (PAGE_LOG2),
      .SUBPAGE_LIMIT(SUBPAGE_LIMIT)
   ) u_page (
      .request_size(req_size_ff),
      .rounded_size(cls_in.rounded_size),
      .delta_log2  (cls_in.delta_log2),
      .pg          (pg_in)
   );

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_free       = !req_valid_ff || rsp_free;
   assign req_chan.ready = req_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_free) begin
            req_valid_ff <= req_chan.valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
      if (req_free && req_chan.valid) begin
         req_size_ff <= req_chan.request_size;
      end
      if (rsp_free && req_valid_ff) begin
         cls_ff <= cls_in;
         pg_ff  <= pg_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.rounded_size = cls_ff.rounded_size;
   assign rsp_chan.group_log2   = cls_ff.group_log2;
   assign rsp_chan.delta_log2   = cls_ff.delta_log2;
   assign rsp_chan.step_count   = cls_ff.step_count;
   assign rsp_chan.was_exact    = cls_ff.was_exact;
   assign rsp_chan.page_count   = pg_ff.page_count;
   assign rsp_chan.multi_page   = pg_ff.multi_page;
   assign rsp_chan.sub_page     = pg_ff.sub_page;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the allocation size-class rounder
// Sends directed and random allocation sizes through the request channel
// with random idle gaps on both sides, predicts each size class and page
// result in the bench, and compares every returned result field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import asc_pkg::*;

   localparam int QUANTUM_LOG2  = QUANTUM_LOG2_DEF;
   localparam int STEPS_LOG2    = STEPS_LOG2_DEF;
   localparam int PAGE_LOG2     = PAGE_LOG2_DEF;
   localparam int CHUNK_LOG2    = CHUNK_LOG2_DEF;
   localparam int SUBPAGE_LIMIT = SUBPAGE_LIMIT_DEF;

   localparam logic [63:0] QUANTUM_SIZE = 64'd1 << QUANTUM_LOG2;
   localparam logic [63:0] FIRST_TOP    = 64'd1 << (QUANTUM_LOG2 + STEPS_LOG2);
   localparam logic [63:0] CHUNK_BYTES  = 64'd1 << CHUNK_LOG2;
   localparam logic [63:0] PAGE_BYTES   = 64'd1 << PAGE_LOG2;

   localparam int RANDOM_COUNT = 1025;
   localparam int DRAIN_FIRST  = 150;
   localparam int DRAIN_SECOND = 700;
   localparam int HOLD_START   = 300;
   localparam int HOLD_CYCLES  = 150;
   localparam int SETTLE       = 20;

   typedef struct packed {
      class_type cls;
      page_type  pg;
   } size_class_result_type;

   logic clock;
   logic reset;

   asc_req_if req_if();
   asc_rsp_if rsp_if();

   alloc_size_class_rounder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [SIZE_W-1:0]     pending_sizes[$];
   size_class_result_type expected_classes[$];
   int                    accepted_count = 0;
   int                    sent_count = 0;
   int                    fault_count = 0;
   int                    total_count = 0;
   logic                  req_taken = 1'b0;
   logic                  hold_off = 1'b0;
   int                    send_gap = 0;
   int                    send_calm = 0;
   int                    stall_left = 0;
   int                    rsp_calm = 0;

   function automatic size_class_result_type round_to_size_class(
      input logic [SIZE_W-1:0] size);
      logic [63:0]           s;
      logic [63:0]           r;
      logic [63:0]           base;
      logic [63:0]           rem;
      logic [63:0]           n;
      logic [63:0]           pages;
      int                    g;
      int                    d;
      int                    i;
      logic                  exact;
      size_class_result_type res;
      s = {32'b0, size};
      if (s <= QUANTUM_SIZE) begin
         r = QUANTUM_SIZE;
         g = QUANTUM_LOG2;
         d = QUANTUM_LOG2;
         n = '0;
         exact = (s == QUANTUM_SIZE);
      end else if (s > CHUNK_BYTES) begin
         r = s;
         g = 0;
         d = 0;
         n = '0;
         exact = 1'b0;
      end else begin
         if (s <= FIRST_TOP) begin
            g = QUANTUM_LOG2;
            d = QUANTUM_LOG2;
         end else begin
            g = 0;
            for (i = 0; i < 64; i++)
               if (s[i]) g = i;
            d = g - STEPS_LOG2;
         end
         base = 64'd1 << g;
         n = (s - base) >> d;
         rem = s - base - (n << d);
         if (rem == 0) begin
            exact = 1'b1;
            // A power of two is the last step of the group below it.
            if (n == 0 && g > QUANTUM_LOG2) begin
               g = g - 1;
               d = d - 1;
               n = 64'd1 << STEPS_LOG2;
            end
         end else begin
            exact = 1'b0;
            n = n + 1;
         end
         r = (64'd1 << g) + (n << d);
      end
      pages = (s <= PAGE_BYTES) ? 64'd1 : (s + PAGE_BYTES - 1) >> PAGE_LOG2;
      res.cls.rounded_size = r[SIZE_W-1:0];
      res.cls.group_log2   = g[LOG2_W-1:0];
      res.cls.delta_log2   = d[LOG2_W-1:0];
      res.cls.step_count   = n[STEP_W-1:0];
      res.cls.was_exact    = exact;
      res.pg.page_count    = pages[PAGES_W-1:0];
      res.pg.multi_page    = (d >= PAGE_LOG2) || ((r & (PAGE_BYTES - 1)) == 0);
      res.pg.sub_page      = (r <= SUBPAGE_LIMIT);
      return res;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_request_size();
      logic [63:0] v;
      logic [63:0] mask;
      int          k;
      int          e;
      int          w;
      k = $urandom_range(0, 99);
      if (k < 12) begin
         v = 64'($urandom_range(0, 130));
      end else if (k < 27) begin
         e = $urandom_range(0, 31);
         v = (64'd1 << e) + 64'($urandom_range(0, 2)) - 64'd1;
      end else if (k < 42) begin
         e = $urandom_range(QUANTUM_LOG2 + STEPS_LOG2, CHUNK_LOG2);
         v = (64'd1 << e) + (64'($urandom_range(1, 1 << STEPS_LOG2)) << (e - STEPS_LOG2));
         if ($urandom_range(0, 3) == 0) v = v + 64'($urandom_range(0, 2)) - 64'd1;
      end else if (k < 72) begin
         w = $urandom_range(1, CHUNK_LOG2);
         mask = (64'd1 << w) - 1;
         v = (64'($urandom) & mask) | (64'd1 << (w - 1));
      end else if (k < 80) begin
         v = CHUNK_BYTES + 64'($urandom_range(0, 64)) - 64'd32;
      end else begin
         v = 64'($urandom);
      end
      return v[SIZE_W-1:0];
   endfunction

   function automatic int idle_length();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 85) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fault_count++;
      end
   endtask

   always #4 clock = ~clock;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.request_size = '0;
      rsp_if.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_sizes.size() != 0 &&
                      !((sent_count == DRAIN_FIRST || sent_count == DRAIN_SECOND) &&
                        expected_classes.size() != 0)) begin
            req_if.valid <= 1'b1;
            req_if.request_size <= pending_sizes.pop_front();
            sent_count++;
            if (send_calm != 0) begin
               send_calm <= send_calm - 1;
               send_gap <= 0;
            end else begin
               send_gap <= idle_length();
               if ($urandom_range(0, 99) < 3) send_calm <= $urandom_range(20, 80);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || hold_off) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (rsp_calm != 0) begin
            rsp_calm <= rsp_calm - 1;
         end else if ($urandom_range(0, 99) < 20) begin
            stall_left <= idle_length();
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_calm <= $urandom_range(30, 100);
         end
      end
   end

   // The receiver holds off for a long stretch so the block fills and
   // stalls new requests.
   initial begin
      while (accepted_count < HOLD_START) @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin : monitor
      size_class_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_classes.size() == 0) begin
               $error("unexpected result: rounded_size %0d", rsp_if.rounded_size);
               fault_count++;
            end else begin
               want = expected_classes.pop_front();
               check_field("rounded_size", 32'(want.cls.rounded_size),
                           32'(rsp_if.rounded_size));
               check_field("group_log2", 32'(want.cls.group_log2), 32'(rsp_if.group_log2));
               check_field("delta_log2", 32'(want.cls.delta_log2), 32'(rsp_if.delta_log2));
               check_field("step_count", 32'(want.cls.step_count), 32'(rsp_if.step_count));
               check_field("was_exact", 32'(want.cls.was_exact), 32'(rsp_if.was_exact));
               check_field("page_count", 32'(want.pg.page_count), 32'(rsp_if.page_count));
               check_field("multi_page", 32'(want.pg.multi_page), 32'(rsp_if.multi_page));
               check_field("sub_page", 32'(want.pg.sub_page), 32'(rsp_if.sub_page));
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_classes.push_back(round_to_size_class(req_if.request_size));
            accepted_count++;
         end
      end
   end

   initial begin
      pending_sizes = '{
         32'd0, 32'd1, 32'd15, 32'd16, 32'd17, 32'd32, 32'd48, 32'd64, 32'd65,
         32'd80, 32'd96, 32'd112, 32'd128, 32'd129, 32'd8191, 32'd8192, 32'd8193,
         32'd28672, 32'd28673, 32'h00FF_FFFF, 32'h0100_0000, 32'h0100_0001,
         32'h0080_0000, 32'h8000_0000, 32'hFFFF_FFFF
      };
      repeat (RANDOM_COUNT) pending_sizes.push_back(pick_request_size());
      total_count = pending_sizes.size();
      while (accepted_count != total_count) @(posedge clock);
      while (expected_classes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/asc_pkg.sv
hw/rtl/asc_req_if.sv
hw/rtl/asc_rsp_if.sv
hw/rtl/asc_class_calc.sv
hw/rtl/asc_page_calc.sv
hw/rtl/alloc_size_class_rounder.sv
tb/tb_top.sv
